/* rtl/opb_pkg.sv */
// ----------------------------------------------------------------------------
// opb_pkg
// Shared types, format codes and helper functions of the opacity pixel blender
// ----------------------------------------------------------------------------
`default_nettype none

package opb_pkg;

    // source format codes
    localparam logic [1:0] SRC_RGB565   = 2'd0;
    localparam logic [1:0] SRC_RGB888   = 2'd1;
    localparam logic [1:0] SRC_RGBA8888 = 2'd2;

    // destination format codes
    localparam logic DST_RGB565   = 1'b0;
    localparam logic DST_ARGB8888 = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
    localparam logic [1:0] REG_DEST_FORMAT   = 2'd1;
    localparam logic [1:0] REG_OPACITY       = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [7:0] OPACITY_FULL = 8'hFF;
    localparam logic [7:0] OPACITY_NONE = 8'h00;

    // live configuration
    typedef struct packed {
        logic [1:0] source_format;
        logic       dest_format;
        logic [7:0] opacity;
    } cfg_t;

    // one pixel widened to 8 bits a channel
    typedef struct packed {
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } chan_t;

    // beat from the front stages to the mix stages
    typedef struct packed {
        chan_t      src;
        chan_t      dst;
        logic [7:0] eff;
        logic       dest_format;
        logic       write;
    } mix_beat_t;

    // truncating divide by 255 for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] y;
        logic [16:0] t;
        y = {1'b0, x} + 17'd1;
        t = y + {8'b0, y[16:8]};
        return t[15:8];
    endfunction

    // (s*op + d*(255-op)), at most 255*255
    function automatic logic [15:0] mix_sum(input logic [7:0] s, input logic [7:0] d,
                                            input logic [7:0] op);
        logic [15:0] ps;
        logic [15:0] pd;
        ps = 16'(s) * 16'(op);
        pd = 16'(d) * 16'(OPACITY_FULL - op);
        return ps + pd;
    endfunction

endpackage

`default_nettype wire

/* rtl/opb_if.sv */
// ----------------------------------------------------------------------------
// opb_if
// Valid/ready stream interfaces for pixel beats into and out of the blender
// ----------------------------------------------------------------------------
`default_nettype none

interface opb_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] src_pixel;
    logic [31:0] dst_pixel;

    modport source (output valid, output src_pixel, output dst_pixel, input ready);
    modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface opb_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_pixel;
    logic        write_enable;

    modport source (output valid, output out_pixel, output write_enable, input ready);
    modport sink   (input valid, input out_pixel, input write_enable, output ready);
endinterface

`default_nettype wire

/* rtl/opb_cfg_regs.sv */
// ----------------------------------------------------------------------------
// opb_cfg_regs
// Configuration registers: source format, destination format and opacity
// ----------------------------------------------------------------------------
`default_nettype none

module opb_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [opb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [opb_pkg::CFG_DATA_W-1:0]  cfg_data,
    output opb_pkg::cfg_t                        cfg
);

    opb_pkg::cfg_t cfg_reg;
    opb_pkg::cfg_t cfg_next;

    // register decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                opb_pkg::REG_SOURCE_FORMAT: cfg_next.source_format = cfg_data[1:0];
                opb_pkg::REG_DEST_FORMAT:   cfg_next.dest_format   = cfg_data[0];
                opb_pkg::REG_OPACITY:       cfg_next.opacity       = cfg_data[7:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.source_format <= opb_pkg::SRC_RGB565;
            cfg_reg.dest_format   <= opb_pkg::DST_RGB565;
            cfg_reg.opacity       <= opb_pkg::OPACITY_FULL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

/* rtl/opb_front.sv */
// ----------------------------------------------------------------------------
// opb_front
// Stages 1 and 2: widen source and destination to 8-bit channels, then
// scale source alpha by opacity for rgba into rgb565
// ----------------------------------------------------------------------------
`default_nettype none

module opb_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire opb_pkg::cfg_t      cfg,
    opb_in_if.sink                  pix_in,
    output logic                    beat_valid,
    input  wire logic               beat_ready,
    output opb_pkg::mix_beat_t      beat
);

    // stage 1 payload
    typedef struct packed {
        opb_pkg::chan_t src;
        opb_pkg::chan_t dst;
        logic [7:0]     op;
        logic [15:0]    alpha_prod;
        logic           use_eff;
        logic           dest_format;
        logic           write;
    } s1_t;

    logic               s1_valid_reg;
    s1_t                s1_reg;
    s1_t                s1_next;
    logic               s2_valid_reg;
    opb_pkg::mix_beat_t s2_reg;
    opb_pkg::mix_beat_t s2_next;
    logic               s1_ready;
    logic               s2_ready;
    logic               fmt_ok;
    opb_pkg::chan_t     src_w;
    opb_pkg::chan_t     dst_w;
    logic [15:0]        dst_lo;

    // ready chain
    assign s2_ready     = !s2_valid_reg || beat_ready;
    assign s1_ready     = !s1_valid_reg || s2_ready;
    assign pix_in.ready = s1_ready;

    // widen source pixel
    always_comb
    begin
        fmt_ok = 1'b1;
        src_w.a = 8'hFF;
        src_w.r = pix_in.src_pixel[23:16];
        src_w.g = pix_in.src_pixel[15:8];
        src_w.b = pix_in.src_pixel[7:0];
        unique case (cfg.source_format)
            opb_pkg::SRC_RGB565:
            begin
                src_w.r = {pix_in.src_pixel[15:11], 3'b000};
                src_w.g = {pix_in.src_pixel[10:5], 2'b00};
                src_w.b = {pix_in.src_pixel[4:0], 3'b000};
            end
            opb_pkg::SRC_RGB888:
            begin
                src_w.a = 8'hFF;
            end
            opb_pkg::SRC_RGBA8888:
            begin
                src_w.a = pix_in.src_pixel[31:24];
            end
            default:
            begin
                fmt_ok = 1'b0;
            end
        endcase
    end

    // widen destination pixel
    always_comb
    begin
        dst_lo = pix_in.dst_pixel[15:0];
        if (cfg.dest_format == opb_pkg::DST_RGB565)
        begin
            dst_w.a = 8'h00;
            dst_w.r = {dst_lo[15:11], 3'b000};
            dst_w.g = {dst_lo[10:5], 2'b00};
            dst_w.b = {dst_lo[4:0], 3'b000};
        end
        else
        begin
            dst_w.a = pix_in.dst_pixel[31:24];
            dst_w.r = pix_in.dst_pixel[23:16];
            dst_w.g = pix_in.dst_pixel[15:8];
            dst_w.b = pix_in.dst_pixel[7:0];
        end
    end

    // stage 1: a skipped write mixes the destination with itself
    always_comb
    begin
        s1_next.write       = fmt_ok && (cfg.opacity != opb_pkg::OPACITY_NONE);
        s1_next.dst         = dst_w;
        s1_next.src         = s1_next.write ? src_w : dst_w;
        s1_next.op          = cfg.opacity;
        s1_next.dest_format = cfg.dest_format;
        s1_next.use_eff     = (cfg.dest_format == opb_pkg::DST_RGB565)
                           && (cfg.source_format == opb_pkg::SRC_RGBA8888)
                           && (cfg.opacity != opb_pkg::OPACITY_FULL);
        s1_next.alpha_prod  = 16'(src_w.a) * 16'(cfg.opacity);
    end

    // stage 2: effective opacity
    always_comb
    begin
        s2_next.src         = s1_reg.src;
        s2_next.dst         = s1_reg.dst;
        s2_next.dest_format = s1_reg.dest_format;
        s2_next.write       = s1_reg.write;
        s2_next.eff         = s1_reg.use_eff ? opb_pkg::div255(s1_reg.alpha_prod) : s1_reg.op;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= pix_in.valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s1_ready && pix_in.valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign beat_valid = s2_valid_reg;
    assign beat       = s2_reg;

endmodule

`default_nettype wire

/* rtl/opb_mix.sv */
// ----------------------------------------------------------------------------
// opb_mix
// Stages 3 and 4: per-channel weighted sums, divide by 255 and pack into the
// destination format
// ----------------------------------------------------------------------------
`default_nettype none

module opb_mix (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               beat_valid,
    output logic                    beat_ready,
    input  wire opb_pkg::mix_beat_t beat,
    opb_out_if.source               pix_out
);

    // stage 3 payload
    typedef struct packed {
        logic [15:0] sum_a;
        logic [15:0] sum_r;
        logic [15:0] sum_g;
        logic [15:0] sum_b;
        logic        dest_format;
        logic        write;
    } s3_t;

    // stage 4 payload
    typedef struct packed {
        logic [31:0] pixel;
        logic        write;
    } s4_t;

    logic           s3_valid_reg;
    s3_t            s3_reg;
    s3_t            s3_next;
    logic           s4_valid_reg;
    s4_t            s4_reg;
    s4_t            s4_next;
    logic           s3_ready;
    logic           s4_ready;
    opb_pkg::chan_t mixed;

    // ready chain
    assign s4_ready   = !s4_valid_reg || pix_out.ready;
    assign s3_ready   = !s3_valid_reg || s4_ready;
    assign beat_ready = s3_ready;

    // stage 3: weighted sums
    always_comb
    begin
        s3_next.sum_a       = opb_pkg::mix_sum(beat.src.a, beat.dst.a, beat.eff);
        s3_next.sum_r       = opb_pkg::mix_sum(beat.src.r, beat.dst.r, beat.eff);
        s3_next.sum_g       = opb_pkg::mix_sum(beat.src.g, beat.dst.g, beat.eff);
        s3_next.sum_b       = opb_pkg::mix_sum(beat.src.b, beat.dst.b, beat.eff);
        s3_next.dest_format = beat.dest_format;
        s3_next.write       = beat.write;
    end

    // stage 4: divide and pack
    always_comb
    begin
        mixed.a = opb_pkg::div255(s3_reg.sum_a);
        mixed.r = opb_pkg::div255(s3_reg.sum_r);
        mixed.g = opb_pkg::div255(s3_reg.sum_g);
        mixed.b = opb_pkg::div255(s3_reg.sum_b);
        s4_next.write = s3_reg.write;
        if (s3_reg.dest_format == opb_pkg::DST_RGB565)
        begin
            s4_next.pixel = {16'h0000, mixed.r[7:3], mixed.g[7:2], mixed.b[7:3]};
        end
        else
        begin
            s4_next.pixel = {mixed.a, mixed.r, mixed.g, mixed.b};
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
            begin
                s3_valid_reg <= beat_valid;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (s3_ready && beat_valid)
        begin
            s3_reg <= s3_next;
        end
        if (s4_ready && s3_valid_reg)
        begin
            s4_reg <= s4_next;
        end
    end

    assign pix_out.valid        = s4_valid_reg;
    assign pix_out.out_pixel    = s4_reg.pixel;
    assign pix_out.write_enable = s4_reg.write;

endmodule

`default_nettype wire

/* rtl/opacity_pixel_blender.sv */
// ----------------------------------------------------------------------------
// opacity_pixel_blender
// Converts a source pixel to the destination format and blends it by opacity
// ----------------------------------------------------------------------------
// The blender takes one pixel beat per clock while the output is not stalled
// and returns one beat per input beat, in order; widen, alpha scale, weighted
// sums, divide by 255 and pack each hold one register stage, and a stalled
// output holds the pipeline back without losing or repeating a beat.
// Write source_format, dest_format and opacity only while no beats are in
// flight. Opacity 0 or an undefined source format returns the destination
// pixel unchanged with write_enable low.
`default_nettype none

module opacity_pixel_blender (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [opb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [opb_pkg::CFG_DATA_W-1:0]  cfg_data,
    opb_in_if.sink                               pix_in,
    opb_out_if.source                            pix_out
);

    opb_pkg::cfg_t      cfg;
    logic               mid_valid;
    logic               mid_ready;
    opb_pkg::mix_beat_t mid_beat;

    // configuration
    opb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // widen and alpha scale
    opb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .pix_in     (pix_in),
        .beat_valid (mid_valid),
        .beat_ready (mid_ready),
        .beat       (mid_beat)
    );

    // mix and pack
    opb_mix u_mix (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (mid_valid),
        .beat_ready (mid_ready),
        .beat       (mid_beat),
        .pix_out    (pix_out)
    );

endmodule

`default_nettype wire
